>>> sv/fnlm_pkg.sv
package fnlm_pkg;

    // grid geometry
    localparam int MAX_GRID = 1024;
    localparam int COL_W    = $clog2(MAX_GRID);
    localparam int SIZE_W   = COL_W + 1;
    localparam int SUM_W    = SIZE_W + 1;
    localparam int DEPTH_W  = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_GRID);

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // one result word
    typedef struct packed {
        logic [DEPTH_W-1:0] cell_depth;
        logic               is_cavity;
        logic               end_of_frame;
        logic               last;
    } t_result;

    // write port of a line store
    typedef struct packed {
        logic               we;
        logic [COL_W-1:0]   addr;
        logic [DEPTH_W-1:0] data;
    } t_line_wr;

endpackage

>>> sv/fnlm_ram.sv
module fnlm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> sv/fnlm_line_buf.sv
module fnlm_line_buf
    import fnlm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_line_wr           i_wr,
    input  logic [COL_W-1:0]   i_raddr,
    output logic [DEPTH_W-1:0] o_rdata
);

    logic [DEPTH_W-1:0] w_ram_q;
    logic               r_byp;
    logic               n_byp;
    logic [DEPTH_W-1:0] r_byp_data;

    fnlm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_GRID)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.we),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_raddr (i_raddr),
        .o_rdata (w_ram_q)
    );

    // forward a word written to the address being read in the same cycle
    assign n_byp = i_wr.we && (i_wr.addr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_wr.data;
    end

    assign o_rdata = r_byp ? r_byp_data : w_ram_q;

`ifndef SYNTH
    a_bypass_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.we && (i_wr.addr == i_raddr)) |=> (o_rdata == $past(i_wr.data)))
        else $error("line store read missed a same-cycle write");
`endif

endmodule

>>> sv/fnlm_res_queue.sv
module fnlm_res_queue
    import fnlm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_word0,
    input  t_result    i_word1,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_word
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic [QPTR_W-1:0] w_wr_1;
    logic              w_pop;

    // pointer and fill bookkeeping
    always_comb begin
        w_pop   = (r_count != '0) && !i_stall;
        w_wr_1  = r_wr + QPTR_W'(1);
        n_wr    = r_wr + QPTR_W'(i_push_n);
        n_rd    = w_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_count = r_count + QCNT_W'(i_push_n) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // store up to two words per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_word0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr_1] <= i_word1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    assign o_full  = (r_count > QCNT_W'(QUEUE_DEPTH - 2));

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QCNT_W'(i_push_n) + r_count) <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |=> o_valid)
        else $error("pushed word not visible");
`endif

endmodule

>>> sv/four_neighbour_local_max_marker_core.sv
// Results: a result word is written into the result queue when the input word that causes it
// is accepted; words of the first row of a frame (grid size two or more) give none.
// Throughput: one input word per cycle while the result queue is not full; on the last row each
// input gives two results (grid size two or more), so the single output port holds the input back.
// Reset (synchronous, active low): grid size 1024, row and column at zero, result queue empty;
// the line stores are not cleared and the block accepts input right after reset.
module four_neighbour_local_max_marker_core
    import fnlm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DEPTH_W-1:0] i_depth,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DEPTH_W-1:0] o_cell_depth,
    output logic               o_is_cavity,
    output logic               o_end_of_frame,
    output logic               o_last
);

    logic [SIZE_W-1:0]  r_size;
    logic [COL_W-1:0]   r_row;
    logic [COL_W-1:0]   n_row;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [COL_W-1:0]   w_col_right;
    logic [DEPTH_W-1:0] r_left;
    logic [SIZE_W-1:0]  w_n;
    logic [SUM_W-1:0]   w_row_p1;
    logic [SUM_W-1:0]   w_col_p1;
    logic [SUM_W-1:0]   w_col_p2;
    logic [SUM_W-1:0]   w_n_ext;
    logic               w_acc;
    logic               w_full;
    logic               w_has_upper;
    logic               w_last_row;
    logic               w_end_row;
    logic               w_interior;
    logic               w_cav;
    logic [DEPTH_W-1:0] w_centre;
    logic [DEPTH_W-1:0] w_up;
    logic [DEPTH_W-1:0] w_right;
    t_line_wr           w_wr_prev;
    t_line_wr           w_wr_old;
    t_result            w_res_up;
    t_result            w_res_low;
    t_result            w_word0;
    t_result            w_word1;
    t_result            w_out;
    logic [1:0]         w_push_n;

    // size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // clamp size into one..MAX_GRID
    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_GRID)) begin
            w_n = SIZE_W'(MAX_GRID);
        end else begin
            w_n = r_size;
        end
    end

    assign w_acc = i_in_valid && !o_in_stall;

    // position tests and the four-neighbour compare
    always_comb begin
        w_n_ext     = SUM_W'(w_n);
        w_row_p1    = SUM_W'(r_row) + SUM_W'(1);
        w_col_p1    = SUM_W'(r_col) + SUM_W'(1);
        w_col_p2    = SUM_W'(r_col) + SUM_W'(2);
        w_has_upper = (r_row != '0);
        w_last_row  = (w_row_p1 >= w_n_ext);
        w_end_row   = (w_col_p1 >= w_n_ext);
        w_interior  = (r_row >= COL_W'(2)) && (w_row_p1 <= w_n_ext) &&
                      (r_col != '0) && (w_col_p2 <= w_n_ext);
        w_cav       = w_interior && (w_up < w_centre) && (r_left < w_centre) &&
                      (w_right < w_centre) && (i_depth < w_centre);
    end

    // advance row and column
    always_comb begin
        if (w_acc && w_end_row) begin
            n_col = '0;
            n_row = w_last_row ? '0 : w_row_p1[COL_W-1:0];
        end else if (w_acc) begin
            n_col = w_col_p1[COL_W-1:0];
            n_row = r_row;
        end else begin
            n_col = r_col;
            n_row = r_row;
        end
        w_col_right = n_col + COL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // left neighbour is the centre of the previous word in the row
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_left <= w_centre;
        end
    end

    // line store writes
    always_comb begin
        w_wr_prev.we   = w_acc;
        w_wr_prev.addr = r_col;
        w_wr_prev.data = i_depth;
        w_wr_old.we    = w_acc && w_has_upper;
        w_wr_old.addr  = r_col;
        w_wr_old.data  = w_centre;
    end

    // previous row at this column
    fnlm_line_buf u_prev_centre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr_prev),
        .i_raddr (n_col),
        .o_rdata (w_centre)
    );

    // previous row one column on
    fnlm_line_buf u_prev_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr_prev),
        .i_raddr (w_col_right),
        .o_rdata (w_right)
    );

    // row before the previous one at this column
    fnlm_line_buf u_older (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr_old),
        .i_raddr (n_col),
        .o_rdata (w_up)
    );

    // build the result words of this input word
    always_comb begin
        w_res_up.cell_depth    = w_centre;
        w_res_up.is_cavity     = w_cav;
        w_res_up.end_of_frame  = 1'b0;
        w_res_up.last          = !w_last_row;
        w_res_low.cell_depth   = i_depth;
        w_res_low.is_cavity    = 1'b0;
        w_res_low.end_of_frame = w_end_row;
        w_res_low.last         = 1'b1;
        w_word0  = w_has_upper ? w_res_up : w_res_low;
        w_word1  = w_res_low;
        w_push_n = w_acc ? (2'(w_has_upper) + 2'(w_last_row)) : 2'd0;
    end

    fnlm_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_word0  (w_word0),
        .i_word1  (w_word1),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (w_out)
    );

    assign o_in_stall     = w_full;
    assign o_cell_depth   = w_out.cell_depth;
    assign o_is_cavity    = w_out.is_cavity;
    assign o_end_of_frame = w_out.end_of_frame;
    assign o_last         = w_out.last;

`ifndef SYNTH
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last_row && w_end_row) |=> (r_row == '0 && r_col == '0))
        else $error("frame end did not wrap position");
    a_first_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_has_upper && !w_last_row) |-> (w_push_n == 2'd0))
        else $error("first row produced a result");
`endif

endmodule
